[sv/iso_pkg.sv]
// shared types and constants for the screen orientation detector
package iso_pkg;

  localparam int unsigned NowW   = 32;
  localparam int unsigned AccelW = 15;
  localparam int unsigned GyroW  = 16;
  localparam int unsigned RotW   = 2;
  localparam int unsigned CauseW = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  localparam int unsigned MinIntW = 10;
  localparam int unsigned SettleW = 14;
  localparam int unsigned LockW   = 14;
  localparam int unsigned ThrW    = 24;

  // reset values of the configuration registers
  localparam logic [MinIntW-1:0] MinIntRst = 10'd20;
  localparam logic [SettleW-1:0] SettleRst = 14'd350;
  localparam logic [LockW-1:0]   LockRst   = 14'd650;
  localparam logic [ThrW-1:0]    ThrRst    = 24'd832000;

  // fixed thresholds
  localparam logic [16:0] AccMargin  = 17'd150;
  localparam logic [15:0] AccAxisMin = 16'd550;
  localparam logic [15:0] AccFlatMin = 16'd650;
  localparam logic [16:0] GyroMin    = 17'd192;
  localparam logic [41:0] DecayMul   = 42'd839;
  localparam int unsigned DecayShift = 10;

  typedef logic [RotW-1:0] rot_t;

  typedef enum logic [CauseW-1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_GRAVITY = 2'd1,
    CAUSE_GYRO    = 2'd2
  } cause_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_INTERVAL = 2'd0,
    CFG_SETTLE       = 2'd1,
    CFG_LOCK         = 2'd2,
    CFG_TURN_THR     = 2'd3
  } cfg_idx_e;

  // rotations and quarter-turn steps
  localparam rot_t RotUp    = 2'd0;
  localparam rot_t RotLeft  = 2'd1;
  localparam rot_t RotRight = 2'd3;
  localparam rot_t StepCw   = 2'd1;
  localparam rot_t StepCcw  = 2'd3;

  typedef struct packed {
    logic [NowW-1:0]          now_ms;
    logic                     sample_ok;
    logic signed [AccelW-1:0] accel_x;
    logic signed [AccelW-1:0] accel_y;
    logic signed [AccelW-1:0] accel_z;
    logic signed [GyroW-1:0]  gyro_z;
    logic                     wake_reset;
  } smp_t;

endpackage

[sv/iso_if.sv]
// channel interfaces: sample input, result output, configuration write
interface iso_smp_if import iso_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [NowW-1:0]          now_ms;
  logic                     sample_ok;
  logic signed [AccelW-1:0] accel_x;
  logic signed [AccelW-1:0] accel_y;
  logic signed [AccelW-1:0] accel_z;
  logic signed [GyroW-1:0]  gyro_z;
  logic                     wake_reset;

  modport source (output valid, now_ms, sample_ok, accel_x, accel_y, accel_z, gyro_z,
                  wake_reset, input ready);
  modport sink   (input valid, now_ms, sample_ok, accel_x, accel_y, accel_z, gyro_z,
                  wake_reset, output ready);
endinterface

interface iso_res_if import iso_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RotW-1:0]   rotation;
  logic              changed;
  logic [CauseW-1:0] cause;

  modport source (output valid, rotation, changed, cause, input ready);
  modport sink   (input valid, rotation, changed, cause, output ready);
endinterface

interface iso_cfg_if import iso_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/imu_screen_orientation_detect.sv]
// top level of the imu screen orientation detector
//
// channel   dir  payload                                              transfer
// smp_i     in   now_ms sample_ok accel_x/y/z gyro_z wake_reset       valid & ready
// res_o     out  rotation changed cause                               valid & ready
// cfg_i     in   index data (min_interval, settle, lock, turn_thr)    valid & ready
//
// one sample per cycle sustained while res_o is ready; its transfer loads the input
// register, and the result register is loaded from it once res_o can take the result
// the pass is set by the gyro_z * dt multiply, saturating add and threshold compare
// reset clears the valid flags and detector state and loads the default configuration; cfg_i is always ready
// a stalled res_o holds its result; the input register fills and then smp_i.ready drops
module imu_screen_orientation_detect import iso_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  iso_smp_if.sink   smp_i,
  iso_res_if.source res_o,
  iso_cfg_if.sink   cfg_i
);

  // configuration registers
  logic [MinIntW-1:0] min_int_q;
  logic [SettleW-1:0] settle_q;
  logic [LockW-1:0]   lock_q;
  logic [ThrW-1:0]    thr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_int_q <= MinIntRst;
      settle_q  <= SettleRst;
      lock_q    <= LockRst;
      thr_q     <= ThrRst;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_MIN_INTERVAL: min_int_q <= cfg_i.data[MinIntW-1:0];
        CFG_SETTLE:       settle_q  <= cfg_i.data[SettleW-1:0];
        CFG_LOCK:         lock_q    <= cfg_i.data[LockW-1:0];
        CFG_TURN_THR:     thr_q     <= cfg_i.data[ThrW-1:0];
        default:          ;
      endcase
    end
  end

  // input register and result register handshake
  smp_t   smp_q;
  logic   stg_vld_q;
  logic   res_vld_q;
  rot_t   res_rot_q;
  logic   res_chg_q;
  cause_e res_cause_q;
  logic   fire;

  assign fire        = stg_vld_q && (!res_vld_q || res_o.ready);
  assign smp_i.ready = !stg_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (smp_i.ready) begin
        stg_vld_q <= smp_i.valid;
      end
      if (fire) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_i.valid && smp_i.ready) begin
      smp_q.now_ms     <= smp_i.now_ms;
      smp_q.sample_ok  <= smp_i.sample_ok;
      smp_q.accel_x    <= smp_i.accel_x;
      smp_q.accel_y    <= smp_i.accel_y;
      smp_q.accel_z    <= smp_i.accel_z;
      smp_q.gyro_z     <= smp_i.gyro_z;
      smp_q.wake_reset <= smp_i.wake_reset;
    end
  end

  // detector state
  logic [NowW-1:0]    last_q, last_d;
  rot_t               cur_q, cur_d;
  rot_t               pend_q, pend_d;
  logic [NowW-1:0]    since_q, since_d;
  logic [NowW-1:0]    lock_until_q, lock_until_d;
  logic signed [31:0] acc_q, acc_d;
  logic               chg_d;
  cause_e             cause_d;

  // wake clears timestamp and accumulator before anything else
  logic [NowW-1:0]    last_w;
  logic signed [31:0] acc_w;
  logic [NowW-1:0]    diff, dt, lock_diff, settle_diff;
  logic               pass, locked;

  assign last_w      = smp_q.wake_reset ? '0 : last_q;
  assign acc_w       = smp_q.wake_reset ? '0 : acc_q;
  assign diff        = smp_q.now_ms - last_w;
  assign pass        = diff >= {{(NowW-MinIntW){1'b0}}, min_int_q};
  assign dt          = (last_w == '0) ? '0 : diff;
  assign lock_diff   = smp_q.now_ms - lock_until_q;
  assign locked      = lock_diff[NowW-1];
  assign settle_diff = smp_q.now_ms - since_q;

  // magnitudes of the accel and gyro axes
  logic signed [15:0] ax16, ay16, az16;
  logic [15:0]        aax, aay, aaz;
  logic signed [16:0] gz17;
  logic [16:0]        agz;

  assign ax16 = 16'(smp_q.accel_x);
  assign ay16 = 16'(smp_q.accel_y);
  assign az16 = 16'(smp_q.accel_z);
  assign aax  = ax16[15] ? 16'(-ax16) : 16'(ax16);
  assign aay  = ay16[15] ? 16'(-ay16) : 16'(ay16);
  assign aaz  = az16[15] ? 16'(-az16) : 16'(az16);
  assign gz17 = 17'(smp_q.gyro_z);
  assign agz  = gz17[16] ? 17'(-gz17) : 17'(gz17);

  logic x_dom, y_dom, grav, flat;
  rot_t grav_rot;

  assign x_dom    = ({1'b0, aax} > (17'(aay) + AccMargin)) && (aax > AccAxisMin);
  assign y_dom    = ({1'b0, aay} > (17'(aax) + AccMargin)) && (aay > AccAxisMin);
  assign grav     = x_dom || y_dom;
  assign grav_rot = x_dom ? ((ax16 > 16'sd0) ? RotLeft : RotRight) : RotUp;
  assign flat     = (aaz > AccFlatMin) && (agz > GyroMin);

  // gyro integration with saturation to 32 bits signed
  logic signed [48:0] gz_x, dt_x, prod;
  logic signed [49:0] sum;
  logic signed [31:0] sat;

  assign gz_x = 49'(smp_q.gyro_z);
  assign dt_x = $signed({17'b0, dt});
  assign prod = gz_x * dt_x;
  assign sum  = 50'(acc_w) + 50'(prod);

  always_comb begin
    if ((&sum[49:31]) || !(|sum[49:31])) begin
      sat = sum[31:0];
    end else if (sum[49]) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = 32'sh7fff_ffff;
    end
  end

  // decay by 839/1024 on the magnitude, truncating toward zero
  logic [31:0]        acc_mag, dmag, new_mag;
  logic [41:0]        dprod;
  logic signed [31:0] decayed, acc_new;

  assign acc_mag = acc_w[31] ? 32'(-acc_w) : 32'(acc_w);
  assign dprod   = 42'(acc_mag) * DecayMul;
  assign dmag    = dprod[DecayShift +: 32];
  assign decayed = acc_w[31] ? -$signed(dmag) : $signed(dmag);
  assign acc_new = flat ? sat : decayed;
  assign new_mag = acc_new[31] ? 32'(-acc_new) : 32'(acc_new);

  logic trig;
  rot_t gyro_rot;

  assign trig     = new_mag >= {8'b0, thr_q};
  assign gyro_rot = cur_q + ((!acc_new[31] && (acc_new != '0)) ? StepCw : StepCcw);

  // single-pass state update
  always_comb begin
    last_d       = last_w;
    cur_d        = cur_q;
    pend_d       = pend_q;
    since_d      = since_q;
    lock_until_d = lock_until_q;
    acc_d        = acc_w;
    chg_d        = 1'b0;
    cause_d      = CAUSE_NONE;
    if (pass) begin
      last_d = smp_q.now_ms;
      if (smp_q.sample_ok) begin
        if (locked) begin
          acc_d = '0;
        end else if (!grav) begin
          acc_d = acc_new;
          if (trig) begin
            acc_d        = '0;
            lock_until_d = smp_q.now_ms + NowW'(lock_q);
            cur_d        = gyro_rot;
            pend_d       = gyro_rot;
            chg_d        = 1'b1;
            cause_d      = CAUSE_GYRO;
          end
        end else begin
          acc_d = '0;
          if (grav_rot != pend_q) begin
            pend_d  = grav_rot;
            since_d = smp_q.now_ms;
          end else if ((grav_rot != cur_q) &&
                       (settle_diff >= NowW'(settle_q))) begin
            cur_d        = grav_rot;
            lock_until_d = smp_q.now_ms + NowW'(lock_q);
            chg_d        = 1'b1;
            cause_d      = CAUSE_GRAVITY;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q       <= '0;
      cur_q        <= '0;
      pend_q       <= '0;
      since_q      <= '0;
      lock_until_q <= '0;
      acc_q        <= '0;
    end else if (fire) begin
      last_q       <= last_d;
      cur_q        <= cur_d;
      pend_q       <= pend_d;
      since_q      <= since_d;
      lock_until_q <= lock_until_d;
      acc_q        <= acc_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_rot_q   <= cur_d;
      res_chg_q   <= chg_d;
      res_cause_q <= cause_d;
    end
  end

  assign res_o.valid    = res_vld_q;
  assign res_o.rotation = res_rot_q;
  assign res_o.changed  = res_chg_q;
  assign res_o.cause    = res_cause_q;

  // checks
  a_cause_matches_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> (res_chg_q == (res_cause_q != CAUSE_NONE)))
    else $error("cause and changed disagree");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_vld_q && res_vld_q && !res_o.ready) |-> !smp_i.ready)
    else $error("input taken while the stage is blocked");

  a_gyro_clears_accum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (cause_d == CAUSE_GYRO)) |=> (acc_q == '0))
    else $error("accumulator not cleared after gyro turn");

  a_change_moves_rotation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && chg_d) |=> (cur_q != $past(cur_q)))
    else $error("reported change left the rotation as it was");

endmodule

[tb/imu_screen_orientation_detect_chk.sv]
// checker for the screen orientation detector: predicts every result and compares it
module imu_screen_orientation_detect_chk import iso_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  iso_smp_if          smp_i,
  iso_res_if          res_i,
  iso_cfg_if          cfg_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint MarginMg   = 150;
  localparam longint AxisMinMg  = 550;
  localparam longint FlatMinMg  = 650;
  localparam longint SpinMinRaw = 192;
  localparam longint FadeMul    = 839;
  localparam int     FadeShift  = 10;
  localparam longint SumMax     = 64'sd2147483647;
  localparam longint SumMin     = -64'sd2147483648;

  typedef struct packed {
    rot_t   rotation;
    logic   changed;
    cause_e cause;
  } orient_t;

  // configuration copy
  logic [MinIntW-1:0] gap_ms;
  logic [SettleW-1:0] hold_ms;
  logic [LockW-1:0]   freeze_ms;
  logic [ThrW-1:0]    turn_lim;

  // detector state copy
  logic [NowW-1:0] last_ms;
  logic [NowW-1:0] pend_since;
  logic [NowW-1:0] freeze_until;
  rot_t            cur_rot;
  rot_t            pend_rot;
  longint          turn_sum;

  orient_t     orient_due_q[$];
  int unsigned mismatch_cnt = 0;

  function automatic longint mag_of(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // one sample through the detector, updates the state copy
  function automatic orient_t orient_step(smp_t s);
    logic [NowW-1:0] dt;
    logic [NowW-1:0] since;
    longint          ax, ay, gz, aax, aay, fade;
    rot_t            want;
    logic            grav;
    orient_t         r;
    r.changed = 1'b0;
    r.cause   = CAUSE_NONE;
    ax  = longint'(s.accel_x);
    ay  = longint'(s.accel_y);
    gz  = longint'(s.gyro_z);
    aax = mag_of(ax);
    aay = mag_of(ay);
    if (s.wake_reset) begin
      last_ms  = '0;
      turn_sum = 0;
    end
    if ((s.now_ms - last_ms) >= NowW'(gap_ms)) begin
      // the first sample after a clear has no interval
      dt      = (last_ms == '0) ? '0 : s.now_ms - last_ms;
      last_ms = s.now_ms;
      if (s.sample_ok) begin
        since = s.now_ms - freeze_until;
        if (since[NowW-1]) begin
          turn_sum = 0;
        end else begin
          want = cur_rot;
          grav = 1'b1;
          if (aax > aay + MarginMg && aax > AxisMinMg) begin
            want = (ax > 0) ? RotLeft : RotRight;
          end else if (aay > aax + MarginMg && aay > AxisMinMg) begin
            want = RotUp;
          end else begin
            grav = 1'b0;
          end
          if (!grav) begin
            if (mag_of(longint'(s.accel_z)) > FlatMinMg && mag_of(gz) > SpinMinRaw) begin
              turn_sum = turn_sum + gz * longint'(dt);
              if (turn_sum > SumMax) turn_sum = SumMax;
              if (turn_sum < SumMin) turn_sum = SumMin;
            end else begin
              fade     = (mag_of(turn_sum) * FadeMul) >>> FadeShift;
              turn_sum = (turn_sum < 0) ? -fade : fade;
            end
            if (mag_of(turn_sum) >= longint'(turn_lim)) begin
              want         = cur_rot + ((turn_sum > 0) ? StepCw : StepCcw);
              turn_sum     = 0;
              freeze_until = s.now_ms + NowW'(freeze_ms);
              cur_rot      = want;
              pend_rot     = want;
              r.changed    = 1'b1;
              r.cause      = CAUSE_GYRO;
            end
          end else begin
            turn_sum = 0;
            if (want != pend_rot) begin
              pend_rot   = want;
              pend_since = s.now_ms;
            end else if (want != cur_rot && (s.now_ms - pend_since) >= NowW'(hold_ms)) begin
              cur_rot      = want;
              freeze_until = s.now_ms + NowW'(freeze_ms);
              r.changed    = 1'b1;
              r.cause      = CAUSE_GRAVITY;
            end
          end
        end
      end
    end
    r.rotation = cur_rot;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    smp_t    smp;
    orient_t want_res;
    if (!rst_ni) begin
      gap_ms       = 10'd20;
      hold_ms      = 14'd350;
      freeze_ms    = 14'd650;
      turn_lim     = 24'd832000;
      last_ms      = '0;
      pend_since   = '0;
      freeze_until = '0;
      cur_rot      = '0;
      pend_rot     = '0;
      turn_sum     = 0;
      orient_due_q.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (orient_due_q.size() == 0) begin
          $display("%0t: result with nothing expected, got rotation %0d changed %0d cause %0d",
                   $time, res_i.rotation, res_i.changed, res_i.cause);
          mismatch_cnt++;
        end else begin
          want_res = orient_due_q.pop_front();
          if (res_i.rotation !== want_res.rotation) begin
            $display("%0t: rotation mismatch, expected %0d, got %0d",
                     $time, want_res.rotation, res_i.rotation);
            mismatch_cnt++;
          end
          if (res_i.changed !== want_res.changed) begin
            $display("%0t: changed mismatch, expected %0d, got %0d",
                     $time, want_res.changed, res_i.changed);
            mismatch_cnt++;
          end
          if (res_i.cause !== want_res.cause) begin
            $display("%0t: cause mismatch, expected %0d, got %0d",
                     $time, want_res.cause, res_i.cause);
            mismatch_cnt++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_MIN_INTERVAL: gap_ms    = cfg_i.data[MinIntW-1:0];
          CFG_SETTLE:       hold_ms   = cfg_i.data[SettleW-1:0];
          CFG_LOCK:         freeze_ms = cfg_i.data[LockW-1:0];
          default:          turn_lim  = cfg_i.data[ThrW-1:0];
        endcase
      end
      if (smp_i.valid && smp_i.ready) begin
        smp.now_ms     = smp_i.now_ms;
        smp.sample_ok  = smp_i.sample_ok;
        smp.accel_x    = smp_i.accel_x;
        smp.accel_y    = smp_i.accel_y;
        smp.accel_z    = smp_i.accel_z;
        smp.gyro_z     = smp_i.gyro_z;
        smp.wake_reset = smp_i.wake_reset;
        orient_due_q.push_back(orient_step(smp));
      end
    end
    pending_o = orient_due_q.size();
    errors_o  = mismatch_cnt;
  end

endmodule

[tb/imu_screen_orientation_detect_tb.sv]
// testbench top for the screen orientation detector: stimulus, settings phases and verdict
module imu_screen_orientation_detect_tb;
  import iso_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Phases      = 10;
  localparam int unsigned PhaseItems  = 113;
  localparam int unsigned BurstItems  = 40;   // back-to-back items at the start of a phase
  localparam int unsigned HoldCycles  = 300;  // long receiver hold-off per phase
  localparam int unsigned DrainCycles = 6;    // quiet cycles after the last result transfer
  localparam int unsigned Limit       = 1000000;

  typedef enum logic [1:0] {
    MOT_TILT,    // one gravity axis dominates, so a rotation can settle
    MOT_SPIN,    // lying flat and turning about z
    MOT_JITTER   // anything at all
  } motion_e;

  logic clk;
  logic rst_n;

  iso_smp_if smp_ch ();
  iso_res_if res_ch ();
  iso_cfg_if cfg_ch ();

  int unsigned chk_errors;
  int unsigned chk_pending;
  int unsigned cycles = 0;
  int unsigned hold_reqs = 0;

  // stimulus state
  logic [NowW-1:0]    t_ms;
  logic [MinIntW-1:0] step_min;
  motion_e            motion;
  int unsigned        motion_left = 0;
  logic [1:0]         tilt_dir;
  logic               spin_neg;

  imu_screen_orientation_detect dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .smp_i  (smp_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  imu_screen_orientation_detect_chk chk (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .smp_i     (smp_ch),
    .res_i     (res_ch),
    .cfg_i     (cfg_ch),
    .errors_o  (chk_errors),
    .pending_o (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic int signed_pick(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic smp_t mk_sample(logic [NowW-1:0] now, logic ok, int ax, int ay, int az,
                                     int gz, logic wake);
    smp_t s;
    s.now_ms     = now;
    s.sample_ok  = ok;
    s.accel_x    = AccelW'(ax);
    s.accel_y    = AccelW'(ay);
    s.accel_z    = AccelW'(az);
    s.gyro_z     = GyroW'(gz);
    s.wake_reset = wake;
    return s;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic push_sample(input smp_t s, input int unsigned gap);
    if (gap > 0) begin
      smp_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    smp_ch.valid      <= 1'b1;
    smp_ch.now_ms     <= s.now_ms;
    smp_ch.sample_ok  <= s.sample_ok;
    smp_ch.accel_x    <= s.accel_x;
    smp_ch.accel_y    <= s.accel_y;
    smp_ch.accel_z    <= s.accel_z;
    smp_ch.gyro_z     <= s.gyro_z;
    smp_ch.wake_reset <= s.wake_reset;
    do @(posedge clk); while (!smp_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // settings change only once the detector has gone quiet
  task automatic apply_settings(input int unsigned min_ms, input int unsigned settle,
                                input int unsigned lock, input int unsigned thr);
    smp_ch.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    write_reg(CFG_MIN_INTERVAL, CfgDataW'(min_ms));
    write_reg(CFG_SETTLE, CfgDataW'(settle));
    write_reg(CFG_LOCK, CfgDataW'(lock));
    write_reg(CFG_TURN_THR, CfgDataW'(thr));
    cfg_ch.valid <= 1'b0;
    step_min = MinIntW'(min_ms);
  endtask

  // next sample of a motion run: tilts that settle, flat spins, or plain noise
  task automatic next_sample(output smp_t s);
    int unsigned r, lead, side_mag;
    int          ax, ay, az, gz, lead_s, side_s;
    if (motion_left == 0) begin
      r = $urandom_range(0, 99);
      motion      = (r < 45) ? MOT_TILT : (r < 85) ? MOT_SPIN : MOT_JITTER;
      motion_left = $urandom_range(3, 30);
      tilt_dir    = 2'($urandom_range(0, 3));
      spin_neg    = 1'($urandom_range(0, 1));
    end
    motion_left--;

    // timestamps: mostly legal spacing, sometimes too soon, sometimes a wild jump
    r = $urandom_range(0, 99);
    if (r < 5) begin
      t_ms += $urandom_range(0, step_min);
    end else if (r < 7) begin
      t_ms += $urandom;
    end else begin
      t_ms += step_min + $urandom_range(0, 40 + step_min / 2);
    end

    az = signed_pick(16000);
    case (motion)
      MOT_TILT: begin
        lead     = $urandom_range(560, 16000);
        side_mag = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16000)
                                               : $urandom_range(0, lead - 160);
        lead_s   = tilt_dir[0] ? -int'(lead) : int'(lead);
        side_s   = ($urandom_range(0, 1) != 0) ? -int'(side_mag) : int'(side_mag);
        if (tilt_dir[1]) begin
          ax = side_s;
          ay = lead_s;
        end else begin
          ax = lead_s;
          ay = side_s;
        end
        gz = signed_pick(32767);
      end
      MOT_SPIN: begin
        ax = signed_pick(550);
        ay = signed_pick(550);
        if ($urandom_range(0, 9) != 0) begin
          az = int'($urandom_range(651, 16000));
          if ($urandom_range(0, 1) != 0) az = -az;
        end
        // mostly a deliberate turn, now and then a slow drift that lets the sum fade
        if ($urandom_range(0, 99) < 85) begin
          gz = spin_neg ? -int'($urandom_range(193, 32768)) : int'($urandom_range(193, 32767));
        end else begin
          gz = signed_pick(192);
        end
      end
      default: begin
        ax = signed_pick(16000);
        ay = signed_pick(16000);
        gz = int'($urandom_range(0, 65535)) - 32768;
      end
    endcase
    s = mk_sample(t_ms, ($urandom_range(0, 99) >= 5), ax, ay, az, gz,
                  ($urandom_range(0, 99) < 3));
  endtask

  // result side: random ready with runs, plus one long hold-off per request
  initial begin
    int unsigned run_left, stall_left, hold_left, holds_seen;
    run_left     = 0;
    stall_left   = 0;
    hold_left    = 0;
    holds_seen   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_seen != hold_reqs) begin
        holds_seen = hold_reqs;
        hold_left  = HoldCycles;
      end
      if (!rst_n) begin
        res_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = $urandom_range(0, 30);
          stall_left = pick_idle();
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycles < Limit) begin
      @(posedge clk);
      cycles++;
    end
    $display("imu_screen_orientation_detect_tb: FAIL");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int unsigned min_ms, settle, lock, thr;
    smp_t        s;
    rst_n             = 1'b0;
    smp_ch.valid      = 1'b0;
    smp_ch.now_ms     = '0;
    smp_ch.sample_ok  = 1'b0;
    smp_ch.accel_x    = '0;
    smp_ch.accel_y    = '0;
    smp_ch.accel_z    = '0;
    smp_ch.gyro_z     = '0;
    smp_ch.wake_reset = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_MIN_INTERVAL;
    cfg_ch.data       = '0;
    step_min          = 10'd20;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at reset settings: 20 ms spacing, 350 ms settle, 650 ms lock
    push_sample(mk_sample(32'd0, 1'b1, 0, 0, 0, 0, 1'b0), pick_idle());     // too soon after reset
    push_sample(mk_sample(32'd100, 1'b0, 0, 0, 0, 0, 1'b0), pick_idle());   // bad sample
    push_sample(mk_sample(32'd110, 1'b1, 16000, 0, 0, 0, 1'b0), pick_idle()); // too soon
    push_sample(mk_sample(32'd200, 1'b1, 16000, 0, 0, 0, 1'b0), pick_idle());
    push_sample(mk_sample(32'd600, 1'b1, 16000, -200, 1000, 0, 1'b0), pick_idle()); // settles
    push_sample(mk_sample(32'd700, 1'b1, -16000, 0, 0, 0, 1'b0), pick_idle());  // locked
    push_sample(mk_sample(32'd1300, 1'b1, 0, -16000, 0, 0, 1'b0), pick_idle());
    push_sample(mk_sample(32'd1400, 1'b1, 100, -100, 16000, 32767, 1'b0), pick_idle());
    push_sample(mk_sample(32'd2100, 1'b1, 0, 0, -16000, -32768, 1'b0), pick_idle());
    push_sample(mk_sample(32'd2800, 1'b1, 0, 0, 16000, 0, 1'b0), pick_idle());
    push_sample(mk_sample(32'd3000, 1'b1, 0, 0, -16000, -32768, 1'b1), pick_idle()); // wake
    push_sample(mk_sample(32'd3020, 1'b1, 0, 0, 651, -193, 1'b0), pick_idle());
    push_sample(mk_sample(32'd3040, 1'b1, 0, 0, 650, -193, 1'b0), pick_idle());
    push_sample(mk_sample(32'd3060, 1'b1, 0, 0, -651, 192, 1'b0), pick_idle());
    push_sample(mk_sample(32'd3080, 1'b1, 551, 0, 0, 0, 1'b0), pick_idle());
    push_sample(mk_sample(32'd3100, 1'b1, 550, 0, 0, 0, 1'b0), pick_idle());
    push_sample(mk_sample(32'd3120, 1'b1, 700, 550, 0, 0, 1'b0), pick_idle());
    push_sample(mk_sample(32'd3140, 1'b1, -16000, 15849, 0, 0, 1'b0), pick_idle());
    push_sample(mk_sample(32'hFFFF_FFFF, 1'b1, 0, 16000, 0, 0, 1'b0), pick_idle()); // far behind
    push_sample(mk_sample(32'h0000_0010, 1'b1, 0, 16000, 0, 0, 1'b0), pick_idle()); // wrap, too soon
    push_sample(mk_sample(32'h0000_0030, 1'b1, 0, 16000, 0, 0, 1'b0), pick_idle());
    push_sample(mk_sample(32'h7FFF_0000, 1'b1, 16000, 0, 0, 0, 1'b0), pick_idle());
    t_ms = 32'h7FFF_0000;

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: begin min_ms = 0;    settle = 0;     lock = 0;     thr = 1;        end
        1: begin min_ms = 1000; settle = 10000; lock = 10000; thr = 16000000; end
        2: begin min_ms = 20;   settle = 350;   lock = 650;   thr = 832000;   end
        3: begin min_ms = 10;   settle = 200;   lock = 300;   thr = 0;        end // each unlocked flat step turns
        default: begin
          min_ms = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 1000) : $urandom_range(0, 60);
          settle = $urandom_range(0, 800);
          lock   = $urandom_range(0, 3000);
          thr    = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 1000)
                                                : $urandom_range(1000, 4000000);
        end
      endcase
      apply_settings(min_ms, settle, lock, thr);
      // sometimes start the clock near the wrap
      if ($urandom_range(0, 3) == 0) t_ms = 32'hFFFF_F000 + $urandom_range(0, 4095);
      // result side holds off while the first items of the phase go in back to back
      hold_reqs++;
      for (int i = 0; i < PhaseItems; i++) begin
        next_sample(s);
        push_sample(s, (i < BurstItems) ? 0 : pick_idle());
      end
    end

    smp_ch.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (chk_errors == 0) begin
      $display("imu_screen_orientation_detect_tb: PASS");
    end else begin
      $display("imu_screen_orientation_detect_tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
sv/iso_pkg.sv
sv/iso_if.sv
sv/imu_screen_orientation_detect.sv
tb/imu_screen_orientation_detect_chk.sv
tb/imu_screen_orientation_detect_tb.sv
